/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the top-level design file to check its own logic.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle
`define MPCD_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies another in the next cycle
`define MPCD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/mpcd_pkg.sv */
// ----------------------------------------------------------------------------
// mpcd_pkg
// Types, constants and helper functions of the motor port counter and detect.
// ----------------------------------------------------------------------------
package mpcd_pkg;

	// Field widths
	localparam int ADC_BITS    = 10;
	localparam int REPEAT_BITS = 8;
	localparam int PORT_W      = 2;
	localparam int NUM_PORTS   = 2 ** PORT_W;
	localparam int CFG_W       = 8;
	localparam int COUNT_W     = 32;
	localparam int ROT_W       = 24;
	localparam int MDEG_W      = 20;
	localparam int QUOT_W      = 24;
	localparam int REM_W       = 10;

	// Queue sizes
	localparam int MID_DEPTH = 4;
	localparam int MID_PTR_W = 2;
	localparam int OUT_DEPTH = 8;
	localparam int OUT_PTR_W = 3;

	// Opcodes
	localparam logic [1:0] OP_ADC  = 2'd0;
	localparam logic [1:0] OP_EDGE = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	// Device type codes
	localparam logic [1:0] TYPE_NONE   = 2'd0;
	localparam logic [1:0] TYPE_LARGE  = 2'd1;
	localparam logic [1:0] TYPE_MEDIUM = 2'd2;
	localparam logic [1:0] TYPE_LEGACY = 2'd3;
	localparam logic [2:0] WANT_ANY    = 3'd4;

	// Register indexes (byte address 4*i, index in paddr[2])
	localparam logic REG_TOL        = 1'b0;
	localparam logic REG_MIN_STABLE = 1'b1;
	localparam logic [CFG_W-1:0] TOL_RESET        = 8'd21;
	localparam logic [CFG_W-1:0] MIN_STABLE_RESET = 8'd20;

	// Reference levels of the ID pin
	localparam logic [ADC_BITS-1:0] ADC_MAX       = {ADC_BITS{1'b1}};
	localparam logic [ADC_BITS-1:0] REF_MEDIUM_LO = 10'd74;
	localparam logic [ADC_BITS-1:0] REF_MEDIUM_HI = 10'd862;
	localparam logic [ADC_BITS-1:0] REF_LEGACY_LO = 10'd32;
	localparam logic [ADC_BITS-1:0] REF_LEGACY_MD = 10'd917;
	localparam logic [ADC_BITS-1:0] REF_LEGACY_HI = 10'd1014;

	localparam logic [REPEAT_BITS-1:0] REPEAT_MAX = {REPEAT_BITS{1'b1}};

	// Division by 360: q = (mag * RECIP) >> RECIP_SHIFT, low by at most one
	localparam logic [COUNT_W-1:0] DIV_BY      = 32'd360;
	localparam logic [COUNT_W-1:0] RECIP       = 32'd3054198966;
	localparam int                 RECIP_SHIFT = 40;
	localparam logic [MDEG_W-1:0]  MDEG_SCALE  = 20'd1000;

	// Classified transaction between front and back
	typedef struct packed {
		logic [1:0]        op;
		logic [PORT_W-1:0] port;
		logic [1:0]        det_type;
		logic              step_up;
		logic [2:0]        want;
	} mid_item_t;

	// Back stage result handed to the divider
	typedef struct packed {
		logic               status;
		logic [1:0]         stable;
		logic               read_ok;
		logic [COUNT_W-1:0] count;
	} back_res_t;

	// Finished result
	typedef struct packed {
		logic                     status;
		logic [1:0]               stable;
		logic signed [ROT_W-1:0]  rot;
		logic signed [MDEG_W-1:0] mdeg;
	} out_item_t;

	// Distance from a reference level within tolerance
	function automatic logic near_level(input logic [ADC_BITS-1:0] v,
			input logic [ADC_BITS-1:0] ref_lvl, input logic [CFG_W-1:0] tol);
		logic [ADC_BITS-1:0] d;
		begin
			d = (v >= ref_lvl) ? (v - ref_lvl) : (ref_lvl - v);
			return d <= {{(ADC_BITS-CFG_W){1'b0}}, tol};
		end
	endfunction

	// Classify an ID pin level; order decides
	function automatic logic [1:0] classify(input logic [ADC_BITS-1:0] v,
			input logic [CFG_W-1:0] tol);
		logic [1:0] t;
		begin
			priority if (v == '0 || v == ADC_MAX) begin
				t = TYPE_LARGE;
			end else if (near_level(v, REF_MEDIUM_LO, tol) ||
					near_level(v, REF_MEDIUM_HI, tol)) begin
				t = TYPE_MEDIUM;
			end else if (near_level(v, REF_LEGACY_LO, tol) ||
					near_level(v, REF_LEGACY_MD, tol) ||
					near_level(v, REF_LEGACY_HI, tol)) begin
				t = TYPE_LEGACY;
			end else begin
				t = TYPE_NONE;
			end
			return t;
		end
	endfunction

endpackage

/* design/mpcd_front.sv */
// ----------------------------------------------------------------------------
// mpcd_front
// Accepts input transactions, classifies ADC levels and edge directions, and
// holds the classified transactions in a short queue for the back end.
// ----------------------------------------------------------------------------
module mpcd_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [1:0]                    opcode,
	input  logic [mpcd_pkg::PORT_W-1:0]   port,
	input  logic [mpcd_pkg::ADC_BITS-1:0] adc_sample,
	input  logic                          edge_level,
	input  logic                          direction_level,
	input  logic [2:0]                    expected_type,
	input  logic [mpcd_pkg::CFG_W-1:0]    tolerance,
	output logic                          mid_valid,
	output mpcd_pkg::mid_item_t           mid_item,
	input  logic                          mid_pop
);

	mpcd_pkg::mid_item_t               mem_q [mpcd_pkg::MID_DEPTH];
	logic [mpcd_pkg::MID_PTR_W-1:0]    wr_ptr_q;
	logic [mpcd_pkg::MID_PTR_W-1:0]    rd_ptr_q;
	logic [mpcd_pkg::MID_PTR_W:0]      cnt_q;
	mpcd_pkg::mid_item_t               new_item;
	logic                              do_push;
	logic                              do_pop;

	// Classify the incoming transaction
	always_comb begin
		new_item.op       = opcode;
		new_item.port     = port;
		new_item.det_type = mpcd_pkg::classify(adc_sample, tolerance);
		new_item.step_up  = edge_level ^ direction_level;
		new_item.want     = expected_type;
	end

	assign full      = (cnt_q == (mpcd_pkg::MID_PTR_W+1)'(mpcd_pkg::MID_DEPTH));
	assign mid_valid = (cnt_q != '0);
	assign mid_item  = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = mid_pop && mid_valid;

	// Store classified transactions
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= new_item;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* design/mpcd_back.sv */
// ----------------------------------------------------------------------------
// mpcd_back
// Carries out classified transactions against the per-port state: debounces
// the device type, steps the edge count and checks reads.
// ----------------------------------------------------------------------------
module mpcd_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [mpcd_pkg::CFG_W-1:0]       min_stable,
	input  logic                             mid_valid,
	input  mpcd_pkg::mid_item_t              mid_item,
	output logic                             mid_pop,
	input  logic [mpcd_pkg::OUT_PTR_W:0]     outq_level,
	input  logic [1:0]                       div_busy,
	output logic                             res_valid_s1,
	output mpcd_pkg::back_res_t              res_s1
);

	logic [mpcd_pkg::COUNT_W-1:0]     count_q  [mpcd_pkg::NUM_PORTS];
	logic [1:0]                       last_q   [mpcd_pkg::NUM_PORTS];
	logic [1:0]                       stable_q [mpcd_pkg::NUM_PORTS];
	logic [mpcd_pkg::REPEAT_BITS-1:0] repeat_q [mpcd_pkg::NUM_PORTS];

	logic [mpcd_pkg::COUNT_W-1:0]     cur_count;
	logic [1:0]                       cur_last;
	logic [1:0]                       cur_stable;
	logic [mpcd_pkg::REPEAT_BITS-1:0] cur_repeat;
	logic [mpcd_pkg::COUNT_W-1:0]     nxt_count;
	logic [1:0]                       nxt_last;
	logic [1:0]                       nxt_stable;
	logic [mpcd_pkg::REPEAT_BITS-1:0] nxt_repeat;
	logic [4:0]                       in_flight;
	mpcd_pkg::back_res_t              res_d;

	// Issue only when the output queue has room for everything in flight
	assign in_flight = 5'(outq_level) + 5'(div_busy) + 5'(res_valid_s1);
	assign mid_pop   = mid_valid && (in_flight < 5'(mpcd_pkg::OUT_DEPTH));

	assign cur_count  = count_q[mid_item.port];
	assign cur_last   = last_q[mid_item.port];
	assign cur_stable = stable_q[mid_item.port];
	assign cur_repeat = repeat_q[mid_item.port];

	// Work out the next port state and the result
	always_comb begin
		nxt_count     = cur_count;
		nxt_last      = cur_last;
		nxt_stable    = cur_stable;
		nxt_repeat    = cur_repeat;
		res_d.status  = 1'b0;
		res_d.read_ok = 1'b0;
		res_d.count   = cur_count;
		unique case (mid_item.op)
			mpcd_pkg::OP_ADC: begin
				if (cur_last == mid_item.det_type) begin
					if (cur_repeat != mpcd_pkg::REPEAT_MAX) begin
						nxt_repeat = cur_repeat + 1'b1;
					end
				end else begin
					nxt_last   = mid_item.det_type;
					nxt_repeat = mpcd_pkg::REPEAT_BITS'(1);
				end
				if (nxt_repeat >= mpcd_pkg::REPEAT_BITS'(min_stable)) begin
					nxt_stable = mid_item.det_type;
				end
			end
			mpcd_pkg::OP_EDGE: begin
				nxt_count = mid_item.step_up ? (cur_count + 1'b1) : (cur_count - 1'b1);
			end
			mpcd_pkg::OP_READ: begin
				if (cur_stable == mpcd_pkg::TYPE_NONE ||
						(mid_item.want != mpcd_pkg::WANT_ANY &&
						mid_item.want != {1'b0, cur_stable})) begin
					res_d.status = 1'b1;
				end else begin
					res_d.read_ok = 1'b1;
				end
			end
			default: begin
			end
		endcase
		res_d.stable = nxt_stable;
	end

	// Update port state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mpcd_pkg::NUM_PORTS; i++) begin
				count_q[i]  <= '0;
				last_q[i]   <= mpcd_pkg::TYPE_NONE;
				stable_q[i] <= mpcd_pkg::TYPE_NONE;
				repeat_q[i] <= '0;
			end
		end else if (mid_pop) begin
			count_q[mid_item.port]  <= nxt_count;
			last_q[mid_item.port]   <= nxt_last;
			stable_q[mid_item.port] <= nxt_stable;
			repeat_q[mid_item.port] <= nxt_repeat;
		end
	end

	// Hold the result for the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s1 <= 1'b0;
		end else begin
			res_valid_s1 <= mid_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (mid_pop) begin
			res_s1 <= res_d;
		end
	end

endmodule

/* design/mpcd_div.sv */
// ----------------------------------------------------------------------------
// mpcd_div
// Splits a signed edge count into rotations and millidegrees: reciprocal
// multiply, one correction step, then scale and restore the sign.
// ----------------------------------------------------------------------------
module mpcd_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  mpcd_pkg::back_res_t in_res,
	output logic [1:0]          busy,
	output logic                out_valid,
	output mpcd_pkg::out_item_t out_item
);

	logic                           v_s2;
	logic                           neg_s2;
	logic [mpcd_pkg::COUNT_W-1:0]   mag_s2;
	logic [2*mpcd_pkg::COUNT_W-1:0] prod_s2;
	logic                           status_s2;
	logic [1:0]                     stable_s2;
	logic                           ok_s2;

	logic                           v_s3;
	logic                           neg_s3;
	logic [mpcd_pkg::QUOT_W-1:0]    quot_s3;
	logic [mpcd_pkg::REM_W-1:0]     rem_s3;
	logic                           status_s3;
	logic [1:0]                     stable_s3;
	logic                           ok_s3;

	logic [mpcd_pkg::COUNT_W-1:0]   mag_d;
	logic [mpcd_pkg::QUOT_W-1:0]    quot_est;
	logic [mpcd_pkg::COUNT_W-1:0]   rem_full;
	logic [mpcd_pkg::REM_W-1:0]     rem_est;
	logic [mpcd_pkg::MDEG_W-1:0]    mdeg_mag;

	assign busy = 2'(v_s2) + 2'(v_s3);

	// Take the magnitude and multiply by the reciprocal
	assign mag_d = in_res.count[mpcd_pkg::COUNT_W-1] ? (~in_res.count + 1'b1) : in_res.count;

	always_ff @(posedge clk) begin
		if (in_valid) begin
			neg_s2    <= in_res.count[mpcd_pkg::COUNT_W-1];
			mag_s2    <= mag_d;
			prod_s2   <= mag_d * mpcd_pkg::RECIP;
			status_s2 <= in_res.status;
			stable_s2 <= in_res.stable;
			ok_s2     <= in_res.read_ok;
		end
	end

	// Correct the quotient estimate by one step
	assign quot_est = prod_s2[mpcd_pkg::RECIP_SHIFT +: mpcd_pkg::QUOT_W];
	assign rem_full = mag_s2 - (mpcd_pkg::COUNT_W'(quot_est) * mpcd_pkg::DIV_BY);
	assign rem_est  = rem_full[mpcd_pkg::REM_W-1:0];

	always_ff @(posedge clk) begin
		if (v_s2) begin
			neg_s3    <= neg_s2;
			status_s3 <= status_s2;
			stable_s3 <= stable_s2;
			ok_s3     <= ok_s2;
			if (rem_est >= mpcd_pkg::REM_W'(mpcd_pkg::DIV_BY)) begin
				quot_s3 <= quot_est + 1'b1;
				rem_s3  <= rem_est - mpcd_pkg::REM_W'(mpcd_pkg::DIV_BY);
			end else begin
				quot_s3 <= quot_est;
				rem_s3  <= rem_est;
			end
		end
	end

	// Advance stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= in_valid;
			v_s3 <= v_s2;
		end
	end

	// Scale the remainder, restore the sign, zero unless a good read
	assign mdeg_mag = mpcd_pkg::MDEG_W'(rem_s3) * mpcd_pkg::MDEG_SCALE;

	always_comb begin
		out_item.status = status_s3;
		out_item.stable = stable_s3;
		out_item.rot    = '0;
		out_item.mdeg   = '0;
		if (ok_s3) begin
			out_item.rot  = neg_s3 ? -$signed(quot_s3) : $signed(quot_s3);
			out_item.mdeg = neg_s3 ? -$signed(mdeg_mag) : $signed(mdeg_mag);
		end
	end

	assign out_valid = v_s3;

endmodule

/* design/mpcd_outq.sv */
// ----------------------------------------------------------------------------
// mpcd_outq
// Result queue: holds finished results until the consumer pops them.
// ----------------------------------------------------------------------------
module mpcd_outq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr,
	input  mpcd_pkg::out_item_t          wdata,
	input  logic                         pop,
	output logic                         empty,
	output mpcd_pkg::out_item_t          rdata,
	output logic [mpcd_pkg::OUT_PTR_W:0] level
);

	mpcd_pkg::out_item_t            mem_q [mpcd_pkg::OUT_DEPTH];
	logic [mpcd_pkg::OUT_PTR_W-1:0] wr_ptr_q;
	logic [mpcd_pkg::OUT_PTR_W-1:0] rd_ptr_q;
	logic [mpcd_pkg::OUT_PTR_W:0]   cnt_q;
	logic                           do_pop;

	assign empty  = (cnt_q == '0);
	assign level  = cnt_q;
	assign rdata  = mem_q[rd_ptr_q];
	assign do_pop = pop && !empty;

	// Store results
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({wr, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* design/motor_port_counter_and_detect.sv */
// Path: a pushed transaction passes through the front queue, the state update,
// the reciprocal multiply, the correction and scale, then the result queue.
// Throughput: one transaction per cycle, set by the state update
// in the back end; issue waits while the result queue and the stages feeding
// it already hold 8 results.
// Reset: arst_n clears port state and queues and reloads the register defaults.
// ----------------------------------------------------------------------------
// motor_port_counter_and_detect
// Four motor ports with edge counting and device type detection.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module motor_port_counter_and_detect (
	input  logic                            clk,
	input  logic                            arst_n,
	// Input queue side
	input  logic                            push,
	output logic                            full,
	input  logic [1:0]                      opcode,
	input  logic [mpcd_pkg::PORT_W-1:0]     port,
	input  logic [mpcd_pkg::ADC_BITS-1:0]   adc_sample,
	input  logic                            edge_level,
	input  logic                            direction_level,
	input  logic [2:0]                      expected_type,
	// Result queue side
	output logic                            empty,
	input  logic                            pop,
	output logic                            status,
	output logic [1:0]                      stable_type_out,
	output logic signed [mpcd_pkg::ROT_W-1:0]  rotations,
	output logic signed [mpcd_pkg::MDEG_W-1:0] millidegrees,
	// Configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [2:0]                      paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	logic [mpcd_pkg::CFG_W-1:0]   tolerance_q;
	logic [mpcd_pkg::CFG_W-1:0]   min_stable_q;
	logic                         cfg_we;

	logic                         mid_valid;
	mpcd_pkg::mid_item_t          mid_item;
	logic                         mid_pop;
	logic                         res_valid_s1;
	mpcd_pkg::back_res_t          res_s1;
	logic [1:0]                   div_busy;
	logic                         div_out_valid;
	mpcd_pkg::out_item_t          div_out_item;
	mpcd_pkg::out_item_t          outq_item;
	logic [mpcd_pkg::OUT_PTR_W:0] outq_level;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q  <= mpcd_pkg::TOL_RESET;
			min_stable_q <= mpcd_pkg::MIN_STABLE_RESET;
		end else if (cfg_we) begin
			unique case (paddr[2])
				mpcd_pkg::REG_TOL:        tolerance_q  <= pwdata[mpcd_pkg::CFG_W-1:0];
				mpcd_pkg::REG_MIN_STABLE: min_stable_q <= pwdata[mpcd_pkg::CFG_W-1:0];
				default:                  tolerance_q  <= tolerance_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			mpcd_pkg::REG_TOL:        prdata = 32'(tolerance_q);
			mpcd_pkg::REG_MIN_STABLE: prdata = 32'(min_stable_q);
			default:                  prdata = '0;
		endcase
	end

	mpcd_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.opcode          (opcode),
		.port            (port),
		.adc_sample      (adc_sample),
		.edge_level      (edge_level),
		.direction_level (direction_level),
		.expected_type   (expected_type),
		.tolerance       (tolerance_q),
		.mid_valid       (mid_valid),
		.mid_item        (mid_item),
		.mid_pop         (mid_pop)
	);

	mpcd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.min_stable   (min_stable_q),
		.mid_valid    (mid_valid),
		.mid_item     (mid_item),
		.mid_pop      (mid_pop),
		.outq_level   (outq_level),
		.div_busy     (div_busy),
		.res_valid_s1 (res_valid_s1),
		.res_s1       (res_s1)
	);

	mpcd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid_s1),
		.in_res    (res_s1),
		.busy      (div_busy),
		.out_valid (div_out_valid),
		.out_item  (div_out_item)
	);

	mpcd_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (div_out_valid),
		.wdata  (div_out_item),
		.pop    (pop),
		.empty  (empty),
		.rdata  (outq_item),
		.level  (outq_level)
	);

	// Drive result ports from the head of the result queue
	assign status          = outq_item.status;
	assign stable_type_out = outq_item.stable;
	assign rotations       = outq_item.rot;
	assign millidegrees    = outq_item.mdeg;

	// Checks
	`MPCD_ASSERT_IMPLY(a_mid_pop_valid, mid_pop, mid_valid, "back end popped an empty queue")
	`MPCD_ASSERT_IMPLY(a_outq_room, div_out_valid, outq_level < (mpcd_pkg::OUT_PTR_W+1)'(mpcd_pkg::OUT_DEPTH), "result queue overflow")
	`MPCD_ASSERT_NEXT(a_cfg_tol_write, cfg_we && (paddr[2] == mpcd_pkg::REG_TOL), tolerance_q == $past(pwdata[7:0]), "tolerance write lost")

endmodule
